### src/page_allocator_with_refcounts_defines.svh
// ----------------------------------------------------------------------------
// page allocator assertion macros
// shared assertion helpers for the page allocator rtl
// ----------------------------------------------------------------------------
`ifndef PAGE_ALLOCATOR_WITH_REFCOUNTS_DEFINES_SVH
`define PAGE_ALLOCATOR_WITH_REFCOUNTS_DEFINES_SVH

// checked property, disabled while reset is high
`define PGA_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property, also checked during reset
`define PGA_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/pga_pkg.sv
// ----------------------------------------------------------------------------
// pga_pkg
// types and constants shared by the page allocator modules
// ----------------------------------------------------------------------------
`default_nettype none

package pga_pkg;

   localparam int NUM_PAGES = 4096;
   localparam int REF_BITS  = 8;
   localparam int PAGE_W    = 12;
   localparam int ADDR_W    = $clog2(NUM_PAGES);
   localparam int DEPTH_W   = $clog2(NUM_PAGES + 1);
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 12;

   // opcodes
   localparam logic [2:0] OP_ALLOC = 3'd0;
   localparam logic [2:0] OP_FREE  = 3'd1;
   localparam logic [2:0] OP_INC   = 3'd2;
   localparam logic [2:0] OP_DEC   = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_EMPTY = 3'd1;
   localparam logic [2:0] ST_RANGE = 3'd2;
   localparam logic [2:0] ST_UNREF = 3'd3;
   localparam logic [2:0] ST_COUNT = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_PAGE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_MODE  = 1'd1;

   typedef struct packed {
      logic [2:0]        opcode;
      logic [PAGE_W-1:0] page;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [PAGE_W-1:0]  page_out;
      logic [REF_BITS-1:0] ref_count;
      logic [DEPTH_W-1:0] free_pages;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic out_blocked;
   } stat_type;

endpackage

`default_nettype wire

### src/pga_ram.sv
// ----------------------------------------------------------------------------
// pga_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pga_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/pga_ctrl.sv
// ----------------------------------------------------------------------------
// pga_ctrl
// sequencer: count memory clearing pass, request accept and commit
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_allocator_with_refcounts_defines.svh"

module pga_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire pga_pkg::stat_type stat,
   output pga_pkg::cmd_type       cmd
);

   pga_pkg::state_type state_ff;
   pga_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pga_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.clear  = 1'b0;
      cmd.accept = 1'b0;
      cmd.commit = 1'b0;
      req_stall  = 1'b1;
      unique case (state_ff)
         pga_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) begin
               state_in = pga_pkg::ST_IDLE;
            end
         end
         pga_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = pga_pkg::ST_EXEC;
            end
         end
         pga_pkg::ST_EXEC: begin
            // memory read data is valid here; wait until the result slot frees
            if (!stat.out_blocked) begin
               cmd.commit = 1'b1;
               state_in   = pga_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pga_pkg::ST_CLEAR;
         end
      endcase
   end

   `PGA_ASSERT_ALWAYS(a_reset_clears, clock, $past(reset) |-> state_ff == pga_pkg::ST_CLEAR, "reset did not restart the clearing pass")
   `PGA_ASSERT(a_accept_exec, clock, reset, cmd.accept |=> state_ff == pga_pkg::ST_EXEC, "accepted transaction did not enter execution")
   `PGA_ASSERT(a_commit_idle, clock, reset, cmd.commit |=> state_ff == pga_pkg::ST_IDLE && !cmd.commit, "commit not followed by idle")
   `PGA_ASSERT(a_no_accept_clear, clock, reset, cmd.clear |-> !cmd.accept && !cmd.commit, "transaction taken during clearing pass")

endmodule

`default_nettype wire

### src/pga_dpath.sv
// ----------------------------------------------------------------------------
// pga_dpath
// free stack, count memory, config registers and result register
// ----------------------------------------------------------------------------
`default_nettype none

module pga_dpath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pga_pkg::cmd_type                    cmd,
   output pga_pkg::stat_type                        stat,
   input  wire pga_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output pga_pkg::rsp_type                         rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pga_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [pga_pkg::CSR_DAT_W-1:0]       csr_wdata
);

   localparam int AW = pga_pkg::ADDR_W;
   localparam int DW = pga_pkg::DEPTH_W;
   localparam int RW = pga_pkg::REF_BITS;
   localparam int PW = pga_pkg::PAGE_W;

   localparam logic [RW-1:0] REF_MAX  = '1;
   localparam logic [RW-1:0] REF_ONE  = RW'(1);
   localparam logic [DW-1:0] DEPTH_MAX = DW'(pga_pkg::NUM_PAGES);

   logic [PW-1:0]     first_page_ff, first_page_in;
   logic              init_mode_ff, init_mode_in;
   pga_pkg::req_type  cur_ff, cur_in;
   logic [DW-1:0]     depth_ff, depth_in;
   logic [AW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   pga_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic [RW-1:0]     cnt_rd;
   logic [PW-1:0]     top_rd;
   logic              ref_we;
   logic [AW-1:0]     ref_waddr;
   logic [RW-1:0]     ref_wdata;
   logic [AW-1:0]     ref_raddr;
   logic              stk_we;
   logic [AW-1:0]     stk_waddr;
   logic [AW-1:0]     stk_raddr;

   // execution results
   pga_pkg::rsp_type  res;
   logic              res_ref_we;
   logic [AW-1:0]     res_ref_addr;
   logic [RW-1:0]     res_ref_data;
   logic              res_push;
   logic              res_pop;
   logic              out_of_range;
   logic [RW-1:0]     next_cnt;

   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------- memories
   assign ref_raddr = cmd.accept ? AW'(req_data.page) : AW'(cur_ff.page);
   assign stk_raddr = AW'(depth_ff - DW'(1));
   assign stk_waddr = AW'(depth_ff);

   always_comb begin
      if (cmd.clear) begin
         ref_we    = 1'b1;
         ref_waddr = clr_cnt_ff;
         ref_wdata = '0;
      end else begin
         ref_we    = cmd.commit && res_ref_we;
         ref_waddr = res_ref_addr;
         ref_wdata = res_ref_data;
      end
   end

   assign stk_we = cmd.commit && res_push;

   pga_ram #(
      .WIDTH (RW),
      .DEPTH (pga_pkg::NUM_PAGES)
   ) u_refs (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr (ref_waddr),
      .wr_data (ref_wdata),
      .rd_addr (ref_raddr),
      .rd_data (cnt_rd)
   );

   pga_ram #(
      .WIDTH (PW),
      .DEPTH (pga_pkg::NUM_PAGES)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (cur_ff.page),
      .rd_addr (stk_raddr),
      .rd_data (top_rd)
   );

   // ---------------------------------------------------------------- execute
   assign out_of_range = (cur_ff.page < first_page_ff) ||
                         ({1'b0, cur_ff.page} >= DW'(pga_pkg::NUM_PAGES));
   assign next_cnt = (cnt_rd != '0) ? cnt_rd - REF_ONE : '0;

   always_comb begin
      res.status   = pga_pkg::ST_OK;
      res.page_out = cur_ff.page;
      res.ref_count = cnt_rd;
      res_ref_we   = 1'b0;
      res_ref_addr = AW'(cur_ff.page);
      res_ref_data = cnt_rd;
      res_push     = 1'b0;
      res_pop      = 1'b0;
      if (cur_ff.opcode == pga_pkg::OP_ALLOC) begin
         if (depth_ff == '0) begin
            res.status    = pga_pkg::ST_EMPTY;
            res.page_out  = '0;
            res.ref_count = '0;
         end else begin
            res_pop       = 1'b1;
            res.page_out  = top_rd;
            res.ref_count = REF_ONE;
            res_ref_we    = 1'b1;
            res_ref_addr  = AW'(top_rd);
            res_ref_data  = REF_ONE;
         end
      end else if (out_of_range) begin
         res.status    = pga_pkg::ST_RANGE;
         res.ref_count = '0;
      end else begin
         case (cur_ff.opcode)
            pga_pkg::OP_FREE: begin
               if (cnt_rd == '0 && !init_mode_ff) begin
                  res.status = pga_pkg::ST_UNREF;
               end else if (next_cnt == '0 && depth_ff >= DEPTH_MAX) begin
                  res.status = pga_pkg::ST_COUNT;
               end else begin
                  res_push      = (next_cnt == '0);
                  res_ref_we    = 1'b1;
                  res_ref_data  = next_cnt;
                  res.ref_count = next_cnt;
               end
            end
            pga_pkg::OP_INC: begin
               if (cnt_rd == REF_MAX) begin
                  res.status = pga_pkg::ST_COUNT;
               end else begin
                  res_ref_we    = 1'b1;
                  res_ref_data  = cnt_rd + REF_ONE;
                  res.ref_count = cnt_rd + REF_ONE;
               end
            end
            pga_pkg::OP_DEC: begin
               if (cnt_rd == '0) begin
                  res.status = pga_pkg::ST_COUNT;
               end else begin
                  res_ref_we    = 1'b1;
                  res_ref_data  = next_cnt;
                  res.ref_count = next_cnt;
               end
            end
            // read and unused codes only report the count
            default: begin
               res.status = pga_pkg::ST_OK;
            end
         endcase
      end
      if (res_push) begin
         res.free_pages = depth_ff + DW'(1);
      end else if (res_pop) begin
         res.free_pages = depth_ff - DW'(1);
      end else begin
         res.free_pages = depth_ff;
      end
   end

   // ---------------------------------------------------------------- registers
   always_comb begin
      first_page_in = first_page_ff;
      init_mode_in  = init_mode_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pga_pkg::CSR_FIRST_PAGE: first_page_in = PW'(csr_wdata);
            pga_pkg::CSR_INIT_MODE:  init_mode_in  = csr_wdata[0];
            default: begin
               first_page_in = first_page_ff;
            end
         endcase
      end
      cur_in       = cmd.accept ? req_data : cur_ff;
      depth_in     = cmd.commit ? res.free_pages : depth_ff;
      clr_cnt_in   = cmd.clear ? clr_cnt_ff + AW'(1) : clr_cnt_ff;
      rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = cmd.commit ? res : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_page_ff <= '0;
         init_mode_ff  <= 1'b1;
         depth_ff      <= '0;
         clr_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         first_page_ff <= first_page_in;
         init_mode_ff  <= init_mode_in;
         depth_ff      <= depth_in;
         clr_cnt_ff    <= clr_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign stat.clear_done  = (clr_cnt_ff == AW'(pga_pkg::NUM_PAGES - 1));
   assign stat.out_blocked = rsp_valid_ff && rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;

endmodule

`default_nettype wire

### src/page_allocator_with_refcounts.sv
// results: a request's result is registered when it commits from the execute
//   state, held there while the last result is stalled; the next request is
//   taken after that, once the count read has been written back at commit
// reset: a clearing pass writes zero to all 4096 count entries, one a cycle,
//   with req_stall high until the pass ends; csr writes are taken throughout
// ----------------------------------------------------------------------------
// page_allocator_with_refcounts
// physical page allocator with a lifo free stack and per-page reference counts
// ----------------------------------------------------------------------------
`default_nettype none

module page_allocator_with_refcounts (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire pga_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output pga_pkg::rsp_type                         rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pga_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [pga_pkg::CSR_DAT_W-1:0]       csr_wdata
);

   pga_pkg::cmd_type  cmd;
   pga_pkg::stat_type stat;

   pga_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pga_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

`default_nettype wire

### dv/page_allocator_with_refcounts_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_allocator_with_refcounts_tb
// drives alloc, free and count transactions into the page allocator, keeps
// its own copy of the free stack and count table, and checks every response
// field against it or a hand-worked value; runs a directed table, random
// traffic and a count ceiling sweep, under three idling mixes
// ----------------------------------------------------------------------------

module page_allocator_with_refcounts_tb;

   // opcodes with no function of their own behave as a count read
   localparam logic [2:0] OP_SPARE_LO  = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;
   localparam int HELD_MAX = 48;
   localparam int RANDOM_ITEMS = 150;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                    kind;
      logic [pga_pkg::CSR_IDX_W-1:0]   csr_idx;
      logic [2:0]                      op;
      logic [pga_pkg::PAGE_W-1:0]      pg;
      bit                              pinned;
      pga_pkg::rsp_type                want;
   } step_row_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   pga_pkg::req_type                req_data;
   logic                            rsp_valid;
   logic                            rsp_stall;
   pga_pkg::rsp_type                rsp_data;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [pga_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [pga_pkg::CSR_DAT_W-1:0]   csr_wdata;

   // shadow state of the allocator
   logic [pga_pkg::PAGE_W-1:0]      free_list [pga_pkg::NUM_PAGES];
   logic [pga_pkg::REF_BITS-1:0]    ref_table [pga_pkg::NUM_PAGES];
   logic [pga_pkg::DEPTH_W-1:0]     stack_top;
   logic [pga_pkg::PAGE_W-1:0]      cfg_first_page;
   logic                            cfg_init_mode;

   pga_pkg::rsp_type                outstanding_rsps [$];
   logic [pga_pkg::PAGE_W-1:0]      held_pages [$];
   step_row_type                    directed_rows [$];
   int                              req_idle_pct;
   int                              rsp_idle_pct;
   int                              error_count;

   page_allocator_with_refcounts uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // applies one page operation to the shadow state and returns the response
   function automatic pga_pkg::rsp_type apply_page_op(input logic [2:0] op,
                                                      input logic [pga_pkg::PAGE_W-1:0] pg);
      pga_pkg::rsp_type             r;
      logic [pga_pkg::REF_BITS-1:0] cnt;
      r.status     = pga_pkg::ST_OK;
      r.page_out   = pg;
      r.ref_count  = '0;
      if (op == pga_pkg::OP_ALLOC) begin
         if (stack_top == 0) begin
            r.status   = pga_pkg::ST_EMPTY;
            r.page_out = '0;
         end else begin
            stack_top             = stack_top - 1'b1;
            r.page_out            = free_list[stack_top];
            ref_table[r.page_out] = pga_pkg::REF_BITS'(1);
            r.ref_count           = pga_pkg::REF_BITS'(1);
         end
      end else if (pg < cfg_first_page) begin
         r.status = pga_pkg::ST_RANGE;
      end else begin
         cnt         = ref_table[pg];
         r.ref_count = cnt;
         case (op)
            pga_pkg::OP_FREE: begin
               if (cnt == 0 && !cfg_init_mode) begin
                  r.status = pga_pkg::ST_UNREF;
               end else if (cnt <= 1) begin
                  // count drops to zero, page goes back on the stack
                  if (stack_top >= pga_pkg::NUM_PAGES) begin
                     r.status = pga_pkg::ST_COUNT;
                  end else begin
                     free_list[stack_top] = pg;
                     stack_top            = stack_top + 1'b1;
                     ref_table[pg]        = '0;
                     r.ref_count          = '0;
                  end
               end else begin
                  ref_table[pg] = cnt - 1'b1;
                  r.ref_count   = cnt - 1'b1;
               end
            end
            pga_pkg::OP_INC: begin
               if (cnt == '1) begin
                  r.status = pga_pkg::ST_COUNT;
               end else begin
                  ref_table[pg] = cnt + 1'b1;
                  r.ref_count   = cnt + 1'b1;
               end
            end
            pga_pkg::OP_DEC: begin
               if (cnt == 0) begin
                  r.status = pga_pkg::ST_COUNT;
               end else begin
                  ref_table[pg] = cnt - 1'b1;
                  r.ref_count   = cnt - 1'b1;
               end
            end
            default: ;
         endcase
      end
      r.free_pages = stack_top;
      return r;
   endfunction

   // called just after a falling edge; returns just after a falling edge
   task automatic issue_req(input logic [2:0] op, input logic [pga_pkg::PAGE_W-1:0] pg,
                            input bit pinned, input pga_pkg::rsp_type pinned_rsp);
      pga_pkg::rsp_type r;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data  = {op, pg};
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      r = apply_page_op(op, pg);
      if (op == pga_pkg::OP_ALLOC && r.status == pga_pkg::ST_OK) begin
         held_pages.push_back(r.page_out);
         if (held_pages.size() > HELD_MAX)
            held_pages.delete(0);
      end
      outstanding_rsps.push_back(pinned ? pinned_rsp : r);
      @(negedge clock);
   endtask

   task automatic send(input logic [2:0] op, input logic [pga_pkg::PAGE_W-1:0] pg);
      issue_req(op, pg, 1'b0, '0);
   endtask

   // register writes only once the block has drained
   task automatic write_csr(input logic [pga_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pga_pkg::CSR_DAT_W-1:0] val);
      req_valid = 1'b0;
      while (outstanding_rsps.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == pga_pkg::CSR_FIRST_PAGE)
         cfg_first_page = val[pga_pkg::PAGE_W-1:0];
      else
         cfg_init_mode = val[0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_init_mode(input logic mode);
      logic [pga_pkg::CSR_DAT_W-1:0] v;
      v    = pga_pkg::CSR_DAT_W'($urandom);
      v[0] = mode;
      write_csr(pga_pkg::CSR_INIT_MODE, v);
   endtask

   // seed the stack in init mode, then mostly well-formed traffic on held pages
   task automatic random_phase(input logic [pga_pkg::PAGE_W-1:0] fp, input int n);
      int                         roll;
      logic [pga_pkg::PAGE_W-1:0] pg;
      write_csr(pga_pkg::CSR_FIRST_PAGE, fp);
      write_init_mode(1'b1);
      held_pages.delete();
      repeat (40)
         send(pga_pkg::OP_FREE, pga_pkg::PAGE_W'($urandom_range(pga_pkg::NUM_PAGES - 1, fp)));
      write_init_mode(1'b0);
      repeat (n) begin
         roll = $urandom_range(99);
         if (held_pages.size() != 0)
            pg = held_pages[$urandom_range(held_pages.size() - 1)];
         else
            pg = pga_pkg::PAGE_W'($urandom_range(pga_pkg::NUM_PAGES - 1, fp));
         if (roll < 30)
            send(pga_pkg::OP_ALLOC, pga_pkg::PAGE_W'($urandom));
         else if (roll < 55)
            send(pga_pkg::OP_FREE, pg);
         else if (roll < 70)
            send(pga_pkg::OP_INC, pg);
         else if (roll < 80)
            send(pga_pkg::OP_DEC, pg);
         else if (roll < 90)
            send(pga_pkg::OP_READ, pg);
         else
            send(3'($urandom_range(7)),
                 pga_pkg::PAGE_W'($urandom_range(pga_pkg::NUM_PAGES - 1)));
      end
   endtask

   function automatic void add_req(input logic [2:0] op,
                                   input logic [pga_pkg::PAGE_W-1:0] pg);
      step_row_type s;
      s.kind    = ROW_REQ;
      s.csr_idx = '0;
      s.op      = op;
      s.pg      = pg;
      s.pinned  = 1'b0;
      s.want    = '0;
      directed_rows.push_back(s);
   endfunction

   function automatic void add_pinned(input logic [2:0] op,
                                      input logic [pga_pkg::PAGE_W-1:0] pg,
                                      input logic [2:0] st,
                                      input logic [pga_pkg::PAGE_W-1:0] pout,
                                      input int cnt, input int depth);
      step_row_type s;
      s.kind            = ROW_REQ;
      s.csr_idx         = '0;
      s.op              = op;
      s.pg              = pg;
      s.pinned          = 1'b1;
      s.want.status     = st;
      s.want.page_out   = pout;
      s.want.ref_count  = pga_pkg::REF_BITS'(cnt);
      s.want.free_pages = pga_pkg::DEPTH_W'(depth);
      directed_rows.push_back(s);
   endfunction

   function automatic void add_csr(input logic [pga_pkg::CSR_IDX_W-1:0] idx,
                                   input logic [pga_pkg::PAGE_W-1:0] val);
      step_row_type s;
      s.kind    = ROW_CSR;
      s.csr_idx = idx;
      s.op      = pga_pkg::OP_READ;
      s.pg      = val;
      s.pinned  = 1'b0;
      s.want    = '0;
      directed_rows.push_back(s);
   endfunction

   // response checker
   always @(posedge clock) begin
      pga_pkg::rsp_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (outstanding_rsps.size() == 0) begin
            report_mismatch($sformatf("response with nothing outstanding: %h", rsp_data));
         end else begin
            want = outstanding_rsps.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_data.status, want.status));
            if (rsp_data.page_out !== want.page_out)
               report_mismatch($sformatf("page_out got %0d want %0d",
                                         rsp_data.page_out, want.page_out));
            if (rsp_data.ref_count !== want.ref_count)
               report_mismatch($sformatf("ref_count got %0d want %0d",
                                         rsp_data.ref_count, want.ref_count));
            if (rsp_data.free_pages !== want.free_pages)
               report_mismatch($sformatf("free_pages got %0d want %0d",
                                         rsp_data.free_pages, want.free_pages));
         end
      end
   end

   // receiver stalls
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = ($urandom_range(99) < rsp_idle_pct);
      end
   end

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int p;
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      error_count    = 0;
      req_idle_pct   = 18;
      rsp_idle_pct   = 68;
      stack_top      = '0;
      cfg_first_page = '0;
      cfg_init_mode  = 1'b1;
      for (int i = 0; i < pga_pkg::NUM_PAGES; i++) begin
         ref_table[i] = '0;
         free_list[i] = '0;
      end

      // first_page 16, init mode on; depths worked out by hand
      add_csr(pga_pkg::CSR_FIRST_PAGE, 16);
      add_csr(pga_pkg::CSR_INIT_MODE, 1);
      add_pinned(pga_pkg::OP_ALLOC, 0, pga_pkg::ST_EMPTY, 0, 0, 0);
      add_pinned(pga_pkg::OP_READ, 15, pga_pkg::ST_RANGE, 15, 0, 0);
      add_pinned(pga_pkg::OP_FREE, 0, pga_pkg::ST_RANGE, 0, 0, 0);
      add_pinned(pga_pkg::OP_DEC, 4095, pga_pkg::ST_COUNT, 4095, 0, 0);
      add_pinned(pga_pkg::OP_READ, 4095, pga_pkg::ST_OK, 4095, 0, 0);
      add_pinned(OP_SPARE_LO, 16, pga_pkg::ST_OK, 16, 0, 0);
      add_pinned(OP_SPARE_HI, 4095, pga_pkg::ST_OK, 4095, 0, 0);
      add_pinned(pga_pkg::OP_FREE, 4095, pga_pkg::ST_OK, 4095, 0, 1);
      add_pinned(pga_pkg::OP_FREE, 16, pga_pkg::ST_OK, 16, 0, 2);
      add_req(pga_pkg::OP_FREE, 100);
      add_req(pga_pkg::OP_ALLOC, 4095);
      add_req(pga_pkg::OP_INC, 100);
      add_req(pga_pkg::OP_DEC, 100);
      add_req(pga_pkg::OP_FREE, 100);
      add_req(pga_pkg::OP_ALLOC, 0);
      add_req(pga_pkg::OP_ALLOC, 0);
      add_req(pga_pkg::OP_ALLOC, 0);
      add_pinned(pga_pkg::OP_ALLOC, 0, pga_pkg::ST_EMPTY, 0, 0, 0);
      add_csr(pga_pkg::CSR_INIT_MODE, 0);
      add_pinned(pga_pkg::OP_FREE, 300, pga_pkg::ST_UNREF, 300, 0, 0);
      add_req(pga_pkg::OP_FREE, 4095);
      add_req(pga_pkg::OP_DEC, 16);
      add_req(OP_SPARE_MID, 12'haaa);
      add_csr(pga_pkg::CSR_FIRST_PAGE, 4095);
      add_pinned(pga_pkg::OP_READ, 4094, pga_pkg::ST_RANGE, 4094, 0, 1);
      add_req(pga_pkg::OP_INC, 4095);
      add_csr(pga_pkg::CSR_FIRST_PAGE, 0);
      add_req(pga_pkg::OP_READ, 0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_csr(directed_rows[i].csr_idx, directed_rows[i].pg);
         else
            issue_req(directed_rows[i].op, directed_rows[i].pg,
                      directed_rows[i].pinned, directed_rows[i].want);
      end
      random_phase(0, RANDOM_ITEMS);

      req_idle_pct = 68;
      rsp_idle_pct = 18;
      random_phase(pga_pkg::PAGE_W'($urandom_range(2000, 1)), RANDOM_ITEMS);

      // drive one count into its ceiling and back down
      p = $urandom_range(pga_pkg::NUM_PAGES - 1, cfg_first_page);
      repeat (260) send(pga_pkg::OP_INC, pga_pkg::PAGE_W'(p));
      repeat (3) send(pga_pkg::OP_DEC, pga_pkg::PAGE_W'(p));
      send(pga_pkg::OP_READ, pga_pkg::PAGE_W'(p));

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      random_phase(3968, RANDOM_ITEMS);

      req_valid = 1'b0;
      while (outstanding_rsps.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
